@@ hw/rtl/frtm_pkg.sv @@
// ----------------------------------------------------------------------------
// frtm_pkg
// Shared widths, constants and types of the frame-rate trimmed-mean estimator.
// ----------------------------------------------------------------------------
package frtm_pkg;

   localparam int DUR_W  = 24;   // frame duration, microseconds
   localparam int FPS_W  = 20;   // whole frames per second
   localparam int FRAC_W = 8;    // fraction bits of a rate
   localparam int RATE_W = 28;   // 20.8 rate

   // 1e6 fps in 20.8, also the numerator per kept sample
   localparam logic [RATE_W-1:0] RATE_MAX = 28'd256000000;
   localparam logic [FPS_W-1:0]  FPS_MAX  = 20'd1000000;

   typedef struct packed {
      logic shift;   // new duration enters the chain
      logic load;    // probes take the cell's own value, rank clears
      logic step;    // compare against probe, probe moves one cell on
   } cell_ctrl_type;

endpackage

@@ hw/rtl/frtm_if.sv @@
// ----------------------------------------------------------------------------
// frtm_if
// Valid/ready channels of the estimator: duration beats in, estimate beats out.
// ----------------------------------------------------------------------------
interface frtm_req_if;
   logic                       valid;
   logic                       ready;
   logic [frtm_pkg::DUR_W-1:0] frame_time_us;

   modport source (output valid, output frame_time_us, input ready);
   modport sink   (input valid, input frame_time_us, output ready);
endinterface

interface frtm_rsp_if #(parameter int HELD_W = 4);
   logic                       valid;
   logic                       ready;
   logic [frtm_pkg::FPS_W-1:0] fps_estimate;
   logic [HELD_W-1:0]          samples_held;

   modport source (output valid, output fps_estimate, output samples_held, input ready);
   modport sink   (input valid, input fps_estimate, input samples_held, output ready);
endinterface

@@ hw/rtl/frame_rate_trimmed_mean_estimator.sv @@
// ----------------------------------------------------------------------------
// frame_rate_trimmed_mean_estimator
// Trimmed-mean frame-rate estimate over a sliding window of frame durations.
// ----------------------------------------------------------------------------
// One duration beat in gives one estimate beat out. The window is a chain of
// WINDOW_DEPTH cells; each beat holds the block from the accepting cycle until
// the next beat can be taken: a rank pass and a sum pass over the cell chain,
// the one-bit-a-cycle divider for the rate from the kept sum (a NUM_W =
// clog2(256e6*WINDOW_DEPTH+1) bit numerator), then a pass over the rate
// history whose mean comes from a reciprocal multiply. A new beat is taken
// while the previous estimate still waits in the output register; the last
// step stalls until that estimate has left.
// samples_held is clog2(WINDOW_DEPTH+1) bits wide; HELD_W of the response
// channel must match.
// ----------------------------------------------------------------------------
module frame_rate_trimmed_mean_estimator #(
   parameter int WINDOW_DEPTH   = 11,
   parameter int TRIM_EACH_SIDE = 2,
   parameter int RATE_HISTORY   = 3
) (
   input  logic        clock,
   input  logic        reset,
   frtm_req_if.sink    req_chan,
   frtm_rsp_if.source  rsp_chan
);

   localparam int    IDX_W   = $clog2(WINDOW_DEPTH);
   localparam int    FILL_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int    RS_W    = (RATE_HISTORY > 1) ? $clog2(RATE_HISTORY) : 1;
   localparam int    CNT_W   = $clog2((WINDOW_DEPTH > RATE_HISTORY) ?
                                      WINDOW_DEPTH : RATE_HISTORY);
   localparam int    SUM_W   = frtm_pkg::DUR_W + FILL_W;
   localparam longint NUM_MAX = 64'd256000000 * WINDOW_DEPTH;
   localparam int    NUM_W   = $clog2(NUM_MAX + 1);
   localparam int    TOT_W   = frtm_pkg::RATE_W + $clog2(RATE_HISTORY + 1);
   // whole-fps history sum divided by RATE_HISTORY via reciprocal multiply
   localparam int    HQ_W    = TOT_W - frtm_pkg::FRAC_W;
   localparam int    RCP_SH  = HQ_W + $clog2(RATE_HISTORY);
   localparam int    RCP_W   = RCP_SH + 1;
   localparam int    PROD_W  = HQ_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP_M =
      RCP_W'(((64'd1 << RCP_SH) + 64'(RATE_HISTORY) - 64'd1) / 64'(RATE_HISTORY));

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_LOAD = 8'b0000_0010,
      ST_RANK = 8'b0000_0100,
      ST_SUM  = 8'b0000_1000,
      ST_DST1 = 8'b0001_0000,
      ST_DIV1 = 8'b0010_0000,
      ST_HSUM = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [TOT_W-1:0]              tot_ff, tot_in;
   logic [RS_W-1:0]               slot_ff, slot_in;
   logic [frtm_pkg::RATE_W-1:0]   hist_ff [RATE_HISTORY];
   logic [frtm_pkg::RATE_W-1:0]   hist_in [RATE_HISTORY];
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [frtm_pkg::FPS_W-1:0]    fps_ff, fps_in;
   logic [FILL_W-1:0]             held_ff, held_in;

   logic                          accept;
   frtm_pkg::cell_ctrl_type       cell_ctrl;
   logic [frtm_pkg::DUR_W-1:0]    cell_val [WINDOW_DEPTH];
   logic                          cell_vld [WINDOW_DEPTH];
   logic [frtm_pkg::DUR_W-1:0]    prb_val  [WINDOW_DEPTH];
   logic [IDX_W-1:0]              prb_idx  [WINDOW_DEPTH];
   logic                          prb_vld  [WINDOW_DEPTH];
   logic [IDX_W-1:0]              rank     [WINDOW_DEPTH];

   logic                          div_start;
   logic [NUM_W-1:0]              div_num;
   logic [SUM_W-1:0]              div_den;
   logic                          div_done;
   logic [NUM_W-1:0]              div_quo;

   logic                          trim;
   logic [FILL_W-1:0]             kept_cnt;
   logic [IDX_W-1:0]              sel;
   logic [FILL_W-1:0]             sel_rank;
   logic                          keep;
   logic [frtm_pkg::RATE_W-1:0]   rate_sat;
   logic [PROD_W-1:0]             fps_prod;

   assign accept            = req_chan.valid && req_chan.ready;
   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign cell_ctrl.shift   = accept;
   assign cell_ctrl.load    = (state_ff == ST_LOAD);
   assign cell_ctrl.step    = (state_ff == ST_RANK);

   for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
      localparam int PREV = (g == 0) ? WINDOW_DEPTH - 1 : g - 1;
      logic [frtm_pkg::DUR_W-1:0] sh_val;
      logic                       sh_vld;
      if (g == 0) begin : g_head
         assign sh_val = req_chan.frame_time_us;
         assign sh_vld = 1'b1;
      end else begin : g_body
         assign sh_val = cell_val[g-1];
         assign sh_vld = cell_vld[g-1];
      end
      frtm_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .shift_val  (sh_val),
         .shift_vld  (sh_vld),
         .prb_val_in (prb_val[PREV]),
         .prb_idx_in (prb_idx[PREV]),
         .prb_vld_in (prb_vld[PREV]),
         .val        (cell_val[g]),
         .vld        (cell_vld[g]),
         .prb_val    (prb_val[g]),
         .prb_idx    (prb_idx[g]),
         .prb_vld    (prb_vld[g]),
         .rank       (rank[g])
      );
   end

   frtm_div #(
      .NUM_W (NUM_W),
      .DEN_W (SUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // trimming applies only with more than 2*TRIM_EACH_SIDE samples held
   assign trim     = fill_ff > FILL_W'(2 * TRIM_EACH_SIDE);
   assign kept_cnt = trim ? fill_ff - FILL_W'(2 * TRIM_EACH_SIDE) : fill_ff;
   assign sel      = cnt_ff[IDX_W-1:0];
   assign sel_rank = FILL_W'(rank[sel]);
   assign keep     = cell_vld[sel] &&
                     (!trim || ((sel_rank >= FILL_W'(TRIM_EACH_SIDE)) &&
                                (sel_rank < fill_ff - FILL_W'(TRIM_EACH_SIDE))));
   assign rate_sat = (div_quo > NUM_W'(frtm_pkg::RATE_MAX)) ?
                     frtm_pkg::RATE_MAX : div_quo[frtm_pkg::RATE_W-1:0];

   assign div_start = (state_ff == ST_DST1);
   assign div_num   = NUM_W'(kept_cnt) * NUM_W'(frtm_pkg::RATE_MAX);
   assign div_den   = sum_ff;

   assign fps_prod  = PROD_W'(tot_ff[TOT_W-1:frtm_pkg::FRAC_W]) * PROD_W'(RCP_M);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      tot_in     = tot_ff;
      slot_in    = slot_ff;
      hist_in    = hist_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;
      fps_in     = fps_ff;
      held_in    = held_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (fill_ff != FILL_W'(WINDOW_DEPTH)) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cnt_in   = '0;
            state_in = ST_RANK;
         end
         ST_RANK: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WINDOW_DEPTH - 1)) begin
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (keep) begin
               sum_in = sum_ff + SUM_W'(cell_val[sel]);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WINDOW_DEPTH - 1)) begin
               state_in = ST_DST1;
            end
         end
         ST_DST1: begin
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            if (div_done) begin
               hist_in[slot_ff] = rate_sat;
               slot_in = (slot_ff == RS_W'(RATE_HISTORY - 1)) ? '0 : slot_ff + RS_W'(1);
               cnt_in   = '0;
               tot_in   = '0;
               state_in = ST_HSUM;
            end
         end
         ST_HSUM: begin
            tot_in = tot_ff + TOT_W'(hist_ff[cnt_ff[RS_W-1:0]]);
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RATE_HISTORY - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in = 1'b1;
               fps_in     = fps_prod[RCP_SH +: frtm_pkg::FPS_W];
               held_in    = fill_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         fill_ff    <= '0;
         slot_ff    <= '0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < RATE_HISTORY; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         fill_ff    <= fill_in;
         slot_ff    <= slot_in;
         rsp_vld_ff <= rsp_vld_in;
         hist_ff    <= hist_in;
      end
      sum_ff  <= sum_in;
      tot_ff  <= tot_in;
      fps_ff  <= fps_in;
      held_ff <= held_in;
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.fps_estimate = fps_ff;
   assign rsp_chan.samples_held = held_ff;

   a_fps_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.fps_estimate <= frtm_pkg::FPS_MAX))
      else $error("estimate above 1e6 fps");

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((held_ff != '0) && (held_ff <= FILL_W'(WINDOW_DEPTH))))
      else $error("samples held out of range");

   a_div_phase: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV1))
      else $error("divider finished outside the divide phase");

endmodule

@@ hw/rtl/frtm_cell.sv @@
// ----------------------------------------------------------------------------
// frtm_cell
// One window slot: holds a duration, passes it down the chain on insert, and
// ranks it against probe values that rotate around the ring of cells.
// ----------------------------------------------------------------------------
module frtm_cell #(
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  frtm_pkg::cell_ctrl_type    ctrl,
   input  logic [frtm_pkg::DUR_W-1:0] shift_val,
   input  logic                       shift_vld,
   input  logic [frtm_pkg::DUR_W-1:0] prb_val_in,
   input  logic [IDX_W-1:0]           prb_idx_in,
   input  logic                       prb_vld_in,
   output logic [frtm_pkg::DUR_W-1:0] val,
   output logic                       vld,
   output logic [frtm_pkg::DUR_W-1:0] prb_val,
   output logic [IDX_W-1:0]           prb_idx,
   output logic                       prb_vld,
   output logic [IDX_W-1:0]           rank
);

   logic [frtm_pkg::DUR_W-1:0] val_ff, val_in;
   logic                       vld_ff, vld_in;
   logic [frtm_pkg::DUR_W-1:0] prb_val_ff, prb_val_in_nx;
   logic [IDX_W-1:0]           prb_idx_ff, prb_idx_nx;
   logic                       prb_vld_ff, prb_vld_nx;
   logic [IDX_W-1:0]           rank_ff, rank_in;
   logic                       hit;

   // ties broken by cell position so equal values get distinct ranks
   assign hit = prb_vld_ff &&
                ((prb_val_ff < val_ff) ||
                 ((prb_val_ff == val_ff) && (prb_idx_ff < IDX_W'(CELL_IDX))));

   always_comb begin
      val_in        = val_ff;
      vld_in        = vld_ff;
      prb_val_in_nx = prb_val_ff;
      prb_idx_nx    = prb_idx_ff;
      prb_vld_nx    = prb_vld_ff;
      rank_in       = rank_ff;
      if (ctrl.shift) begin
         val_in = shift_val;
         vld_in = shift_vld;
      end
      if (ctrl.load) begin
         prb_val_in_nx = val_ff;
         prb_idx_nx    = IDX_W'(CELL_IDX);
         prb_vld_nx    = vld_ff;
         rank_in       = '0;
      end else if (ctrl.step) begin
         prb_val_in_nx = prb_val_in;
         prb_idx_nx    = prb_idx_in;
         prb_vld_nx    = prb_vld_in;
         rank_in       = rank_ff + IDX_W'(hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         prb_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         prb_vld_ff <= prb_vld_nx;
      end
      val_ff     <= val_in;
      prb_val_ff <= prb_val_in_nx;
      prb_idx_ff <= prb_idx_nx;
      rank_ff    <= rank_in;
   end

   assign val     = val_ff;
   assign vld     = vld_ff;
   assign prb_val = prb_val_ff;
   assign prb_idx = prb_idx_ff;
   assign prb_vld = prb_vld_ff;
   assign rank    = rank_ff;

endmodule

@@ hw/rtl/frtm_div.sv @@
// ----------------------------------------------------------------------------
// frtm_div
// Restoring unsigned divider, one quotient bit per cycle. Quotient holds
// until the next start. A zero divisor gives an all-ones quotient.
// ----------------------------------------------------------------------------
module frtm_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 28
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] shf_ff, shf_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             ge;

   assign rem_sh  = {rem_ff, shf_ff[NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign ge      = rem_sh >= {1'b0, den_ff};

   always_comb begin
      shf_in  = shf_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         shf_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         shf_in = {shf_ff[NUM_W-2:0], ge};
         rem_in = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shf_ff <= shf_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = shf_ff;

endmodule

@@ bench/frame_rate_trimmed_mean_estimator_test.sv @@
// ----------------------------------------------------------------------------
// frame_rate_trimmed_mean_estimator_test
// Self-checking bench for the trimmed-mean frame-rate estimator.
// Frame durations go in on the request channel. Each accepted duration is run
// through a local model of the window, the trim, the 20.8 rate and the
// three-slot rate average. Every estimate beat is then compared with the
// oldest expected one. A directed pass covers the field extremes, zero
// durations, ties and the full-window shift. After it come about 1900 random
// durations, with bursty input, a stalling receiver, one long receiver
// hold-off and one full drain.
// ----------------------------------------------------------------------------
module frame_rate_trimmed_mean_estimator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN_DEPTH    = 11;
   localparam int TRIM_SIDE    = 2;
   localparam int RING_DEPTH   = 3;
   localparam int HELD_BITS    = 4;
   localparam int RANDOM_BEATS = 1880;
   localparam int BEAT_CYCLES  = 62;
   localparam int LONG_HOLD    = 800;
   localparam int DRAIN_LIMIT  = 50000;

   typedef struct packed {
      logic [frtm_pkg::FPS_W-1:0] fps;
      logic [HELD_BITS-1:0]       held;
   } estimate_type;

   // window model and queue of pending estimates
   class estimate_tracker;
      logic [frtm_pkg::DUR_W-1:0]  dur_win[WIN_DEPTH];
      int unsigned                 fill;
      logic [frtm_pkg::RATE_W-1:0] rate_ring[RING_DEPTH];
      int unsigned                 slot;
      estimate_type                pending_estimates[$];
      int unsigned                 mismatches;
      int unsigned                 durations_seen;
      int unsigned                 estimates_checked;
      int unsigned                 full_window_hits;
      int unsigned                 ceiling_hits;

      function new();
         fill = 0;
         slot = 0;
         mismatches = 0;
         durations_seen = 0;
         estimates_checked = 0;
         full_window_hits = 0;
         ceiling_hits = 0;
         foreach (dur_win[i]) dur_win[i] = '0;
         foreach (rate_ring[i]) rate_ring[i] = '0;
      endfunction

      function void log_duration(logic [frtm_pkg::DUR_W-1:0] d);
         logic [frtm_pkg::DUR_W-1:0] sorted[WIN_DEPTH];
         logic [frtm_pkg::DUR_W-1:0] x;
         int                         lo;
         int                         hi;
         int                         j;
         longint unsigned            sum;
         longint unsigned            kept;
         longint unsigned            q;
         longint unsigned            total;
         estimate_type               e;

         durations_seen++;
         if (fill >= WIN_DEPTH) begin
            for (int i = 1; i < WIN_DEPTH; i++) dur_win[i-1] = dur_win[i];
            dur_win[WIN_DEPTH-1] = d;
            fill = WIN_DEPTH;
         end else begin
            dur_win[fill] = d;
            fill++;
         end
         if (fill == WIN_DEPTH) full_window_hits++;

         for (int i = 0; i < WIN_DEPTH; i++) sorted[i] = dur_win[i];
         for (int i = 1; i < int'(fill); i++) begin
            x = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > x) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = x;
         end

         lo = 0;
         hi = int'(fill);
         if (fill > 2 * TRIM_SIDE) begin
            lo = TRIM_SIDE;
            hi = int'(fill) - TRIM_SIDE;
         end
         sum = 0;
         for (int i = lo; i < hi; i++) sum += sorted[i];
         kept = longint'(hi - lo);
         if (sum == 0) begin
            q = frtm_pkg::RATE_MAX;
         end else begin
            q = (longint'(frtm_pkg::RATE_MAX) * kept) / sum;
            if (q > frtm_pkg::RATE_MAX) q = frtm_pkg::RATE_MAX;
         end

         rate_ring[slot] = q[frtm_pkg::RATE_W-1:0];
         slot = (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;

         total = 0;
         for (int i = 0; i < RING_DEPTH; i++) total += rate_ring[i];
         total = total / (RING_DEPTH * (1 << frtm_pkg::FRAC_W));
         e.fps  = total[frtm_pkg::FPS_W-1:0];
         e.held = fill[HELD_BITS-1:0];
         pending_estimates.push_back(e);
      endfunction

      function void check_estimate(logic [frtm_pkg::FPS_W-1:0] fps,
                                   logic [HELD_BITS-1:0] held);
         estimate_type exp_e;
         estimates_checked++;
         if (fps == frtm_pkg::FPS_MAX) ceiling_hits++;
         if (pending_estimates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("MISMATCH: unexpected estimate beat fps=%0d held=%0d", fps, held);
            return;
         end
         exp_e = pending_estimates.pop_front();
         if (fps !== exp_e.fps || held !== exp_e.held) begin
            mismatches++;
            if (mismatches <= 10)
               $display("MISMATCH: estimate %0d: fps exp %0d got %0d, held exp %0d got %0d",
                        estimates_checked, exp_e.fps, fps, exp_e.held, held);
         end
      endfunction

      function int unsigned outstanding();
         return pending_estimates.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   frtm_req_if                         req_bus ();
   frtm_rsp_if #(.HELD_W(HELD_BITS))   rsp_bus ();

   frame_rate_trimmed_mean_estimator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   estimate_tracker            tracker = new();
   bit                         hold_request = 1'b0;
   logic [frtm_pkg::DUR_W-1:0] last_dur = 24'd16666;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #6ms;
      $display("DONE: errors detected");
      $finish;
   end

   // beat monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.log_duration(req_bus.frame_time_us);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_estimate(rsp_bus.fps_estimate, rsp_bus.samples_held);
      end
   end

   // receiver: stall pattern switches among four modes, picked at random
   initial begin
      int unsigned cyc;
      int unsigned stall_mode;
      int unsigned short_left;
      int unsigned long_left;
      logic        r;

      cyc = 0;
      stall_mode = 0;
      short_left = 0;
      long_left = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         cyc++;
         if (cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
         if (hold_request) begin
            long_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (long_left > 0) begin
            r = 1'b0;
            long_left--;
         end else if (short_left > 0) begin
            r = 1'b0;
            short_left--;
         end else begin
            r = 1'b1;
            case (stall_mode)
               1: begin
                  if ($urandom_range(0, 3) == 0) begin
                     r = 1'b0;
                     short_left = $urandom_range(0, 3);
                  end
               end
               2: begin
                  if ($urandom_range(0, 63) == 0) begin
                     r = 1'b0;
                     short_left = $urandom_range(10, 120);
                  end
               end
               3: r = cyc[0];
               default: r = 1'b1;
            endcase
         end
         rsp_bus.ready <= r;
         @(posedge clock);
      end
   end

   task automatic send_duration(input logic [frtm_pkg::DUR_W-1:0] d);
      req_bus.valid         <= 1'b1;
      req_bus.frame_time_us <= d;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      last_dur = d;
   endtask

   task automatic pause_sender(input int unsigned n);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      int unsigned waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      while (tracker.outstanding() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (tracker.outstanding() != 0) begin
         tracker.mismatches++;
         $display("MISMATCH: %0d estimates never arrived", tracker.outstanding());
      end
   endtask

   function automatic logic [frtm_pkg::DUR_W-1:0] pick_duration(
      input logic [frtm_pkg::DUR_W-1:0] prev);
      int unsigned r;
      logic [31:0] w;
      r = $urandom_range(0, 99);
      w = $urandom;
      if (r < 40)      return frtm_pkg::DUR_W'($urandom_range(4000, 70000));
      else if (r < 55) return w[frtm_pkg::DUR_W-1:0];
      else if (r < 65) return frtm_pkg::DUR_W'($urandom_range(0, 20));
      else if (r < 72) return 24'hFFFFFF - frtm_pkg::DUR_W'($urandom_range(0, 255));
      else if (r < 87) return prev;
      else             return 24'h1 << $urandom_range(0, frtm_pkg::DUR_W - 1);
   endfunction

   initial begin
      logic [frtm_pkg::DUR_W-1:0] directed_durs[$];
      int unsigned                sent;
      int unsigned                burst;
      int unsigned                waited;

      reset                 = 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.frame_time_us <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, zero durations, few samples, ties, full-window shift
      directed_durs = '{24'hFFFFFF, 24'd1, 24'd0, 24'd0, 24'd1,
                        24'd1000, 24'd1000, 24'd1000, 24'd1000, 24'd1000, 24'd1000,
                        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1, 24'd1, 24'd1,
                        24'd16666, 24'd33333, 24'hAAAAAA, 24'h555555, 24'd0};
      foreach (directed_durs[i]) send_duration(directed_durs[i]);
      wait_drained();

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < int'(burst) && sent < RANDOM_BEATS; b++) begin
            send_duration(pick_duration(last_dur));
            sent++;
            if (sent == 600) hold_request = 1'b1;
            if (sent == 1200) wait_drained();
         end
         case ($urandom_range(0, 3))
            0: pause_sender(0);
            1: pause_sender($urandom_range(1, 8));
            2: pause_sender($urandom_range(9, 60));
            default: pause_sender($urandom_range(61, 150));
         endcase
      end
      req_bus.valid <= 1'b0;

      wait_drained();
      waited = 0;
      while (waited < 2 * BEAT_CYCLES) begin
         @(posedge clock);
         waited++;
      end

      $display("Covered %0d duration beats and %0d estimate beats.",
               tracker.durations_seen, tracker.estimates_checked);
      $display("Full window on %0d beats, estimate at the rate ceiling on %0d.",
               tracker.full_window_hits, tracker.ceiling_hits);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("Mismatches: %0d", tracker.mismatches);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
